// ----- hw/rtl/assert_macros.svh -----
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/fscr_pkg.sv -----
package fscr_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] POS_IDLE = 3'd0;
  localparam logic [2:0] POS_FL = 3'd1;
  localparam logic [2:0] POS_FR = 3'd2;
  localparam logic [2:0] POS_BL = 3'd5;
  localparam logic [2:0] POS_BR = 3'd6;
  localparam logic [2:0] POS_CHECK = 3'd7;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECKSUM_SEED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_FL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_FR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_BL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_BR = 3'd5;

  localparam logic [15:0] STEP_PERIOD_RESET = 16'd249;
  localparam logic [7:0] CHECKSUM_SEED_RESET = 8'hAA;

  typedef logic signed [8:0] speed_t;

  typedef struct packed {
    logic operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic fl_forward;
    logic [7:0] fl_duty;
    logic fr_forward;
    logic [7:0] fr_duty;
    logic bl_forward;
    logic [7:0] bl_duty;
    logic br_forward;
    logic [7:0] br_duty;
  } out_item_t;

  typedef struct packed {
    speed_t [NUM_MOTORS-1:0] target;
  } cmd_t;

endpackage

// ----- hw/rtl/framed_speed_command_ramp_top.sv -----
// A tick that completes a step period gives its result on the result ports after it passes
// the command queue and the result queue. Throughput: one item per cycle while full is low,
// bytes and ticks alike; results leave at one per cycle while empty is low.
// Radio byte transactions never give a result.
// Reset (rst, synchronous, active high) clears the frame parser, tick count, targets,
// speeds and both queues, and returns the configuration registers to their reset values.
module framed_speed_command_ramp_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  fscr_pkg::in_item_t                  item,
  output logic                                empty,
  input  logic                                pop,
  output fscr_pkg::out_item_t                 result,
  input  logic                                cfg_we,
  input  logic [fscr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fscr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [15:0] step_period;
  logic [7:0] checksum_seed;
  logic [3:0] invert;

  logic accept;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;
  fscr_pkg::cmd_t cmd_in;
  fscr_pkg::cmd_t cmd_out;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= fscr_pkg::STEP_PERIOD_RESET;
      checksum_seed <= fscr_pkg::CHECKSUM_SEED_RESET;
      invert <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fscr_pkg::REG_STEP_PERIOD: step_period <= cfg_data[15:0];
        fscr_pkg::REG_CHECKSUM_SEED: checksum_seed <= cfg_data[7:0];
        fscr_pkg::REG_INVERT_FL: invert[0] <= cfg_data[0];
        fscr_pkg::REG_INVERT_FR: invert[1] <= cfg_data[0];
        fscr_pkg::REG_INVERT_BL: invert[2] <= cfg_data[0];
        fscr_pkg::REG_INVERT_BR: invert[3] <= cfg_data[0];
        default: ;
      endcase
    end
  end

  fscr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .step_period   (step_period),
    .checksum_seed (checksum_seed),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  fscr_cmd_queue u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out)
  );

  fscr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .invert    (invert),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

// ----- hw/rtl/fscr_front.sv -----
module fscr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  fscr_pkg::in_item_t item,
  input  logic [15:0]       step_period,
  input  logic [7:0]        checksum_seed,
  output logic              cmd_push,
  output fscr_pkg::cmd_t    cmd
);

  logic [2:0] pos;
  logic [7:0] sum;
  logic [7:0] b_fl;
  logic [7:0] b_fr;
  logic [7:0] b_bl;
  logic [7:0] b_br;
  logic [15:0] tick_count;
  fscr_pkg::speed_t [fscr_pkg::NUM_MOTORS-1:0] target;

  logic [16:0] count;
  logic step;
  logic is_tick;
  logic [7:0] rx;

  assign rx = item.rx_byte;
  assign is_tick = (item.operation == fscr_pkg::OP_TICK);
  assign count = {1'b0, tick_count} + 17'd1;
  assign step = !(count < {1'b0, step_period});
  assign cmd_push = accept && is_tick && step;
  assign cmd.target = target;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (accept && is_tick) begin
      tick_count <= step ? '0 : count[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= fscr_pkg::POS_IDLE;
      target <= '0;
    end else if (accept && !is_tick) begin
      if (pos == fscr_pkg::POS_IDLE) begin
        if (rx == fscr_pkg::HEADER_BYTE) begin
          pos <= pos + 3'd1;
        end
      end else if (rx == fscr_pkg::HEADER_BYTE) begin
        pos <= fscr_pkg::POS_IDLE;
      end else if (pos == fscr_pkg::POS_CHECK) begin
        pos <= fscr_pkg::POS_IDLE;
        if (8'(sum + checksum_seed) == rx) begin
          target[0] <= {b_fl, 1'b0};
          target[1] <= {b_fr, 1'b0};
          target[2] <= {b_bl, 1'b0};
          target[3] <= {b_br, 1'b0};
        end
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_tick) begin
      if (pos == fscr_pkg::POS_IDLE) begin
        sum <= '0;
      end else begin
        sum <= sum + rx;
      end
      case (pos)
        fscr_pkg::POS_FL: b_fl <= rx;
        fscr_pkg::POS_FR: b_fr <= rx;
        fscr_pkg::POS_BL: b_bl <= rx;
        fscr_pkg::POS_BR: b_br <= rx;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/fscr_cmd_queue.sv -----
module fscr_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fscr_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output fscr_pkg::cmd_t dout
);

  fscr_pkg::cmd_t mem [fscr_pkg::QUEUE_DEPTH];
  logic [fscr_pkg::QPTR_W-1:0] wr_ptr;
  logic [fscr_pkg::QPTR_W-1:0] rd_ptr;
  logic [fscr_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  function automatic logic [fscr_pkg::QCNT_W-1:0] QCNT_W_ONE(input logic b);
    QCNT_W_ONE = {{(fscr_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign full = (count == fscr_pkg::QCNT_W'(fscr_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W_ONE(do_push) - QCNT_W_ONE(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

// ----- hw/rtl/fscr_back.sv -----
`include "assert_macros.svh"

module fscr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  fscr_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic [3:0]          invert,
  input  logic                pop,
  output logic                empty,
  output fscr_pkg::out_item_t result
);

  fscr_pkg::speed_t [fscr_pkg::NUM_MOTORS-1:0] actual;
  fscr_pkg::speed_t [fscr_pkg::NUM_MOTORS-1:0] actual_next;
  logic [fscr_pkg::NUM_MOTORS-1:0] fwd;
  logic [7:0] duty [fscr_pkg::NUM_MOTORS];
  fscr_pkg::out_item_t res_new;

  fscr_pkg::out_item_t rq [fscr_pkg::QUEUE_DEPTH];
  logic [fscr_pkg::QPTR_W-1:0] wr_ptr;
  logic [fscr_pkg::QPTR_W-1:0] rd_ptr;
  logic [fscr_pkg::QCNT_W-1:0] rq_count;
  logic do_pop;
  logic room;

  assign empty = (rq_count == '0);
  assign do_pop = pop && !empty;
  assign room = (rq_count != fscr_pkg::QCNT_W'(fscr_pkg::QUEUE_DEPTH)) || do_pop;
  assign cmd_pop = !cmd_empty && room;
  assign result = rq[rd_ptr];

  always_comb begin
    logic signed [9:0] s;
    logic [9:0] mag;
    for (int m = 0; m < fscr_pkg::NUM_MOTORS; m++) begin
      if (actual[m] < cmd.target[m]) begin
        actual_next[m] = actual[m] + 9'sd1;
      end else if (actual[m] > cmd.target[m]) begin
        actual_next[m] = actual[m] - 9'sd1;
      end else begin
        actual_next[m] = actual[m];
      end
      s = invert[m] ? -{actual_next[m][8], actual_next[m]} : {actual_next[m][8], actual_next[m]};
      fwd[m] = !s[9];
      mag = s[9] ? 10'(-s) : 10'(s);
      duty[m] = mag[8] ? 8'hFF : mag[7:0];
    end
  end

  always_comb begin
    res_new.fl_forward = fwd[0];
    res_new.fl_duty = duty[0];
    res_new.fr_forward = fwd[1];
    res_new.fr_duty = duty[1];
    res_new.bl_forward = fwd[2];
    res_new.bl_duty = duty[2];
    res_new.br_forward = fwd[3];
    res_new.br_duty = duty[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      actual <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      rq_count <= '0;
    end else begin
      if (cmd_pop) begin
        actual <= actual_next;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (cmd_pop && !do_pop) begin
        rq_count <= rq_count + 1'b1;
      end else if (!cmd_pop && do_pop) begin
        rq_count <= rq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      rq[wr_ptr] <= res_new;
    end
  end

  `ASSERT_ALWAYS(a_rq_bound, clk, rst, rq_count <= fscr_pkg::QCNT_W'(fscr_pkg::QUEUE_DEPTH))
  `ASSERT_NEXT(a_speed_hold, clk, rst, !cmd_pop, $stable(actual))
  `ASSERT_NEXT(a_result_written, clk, rst, cmd_pop, !empty)

endmodule
